/* rtl/core/eic_pkg.sv */
//------------------------------------------------------------------------------
// eic_pkg
// Shared types and register map constants of the external interrupt controller.
//------------------------------------------------------------------------------
`default_nettype none

package eic_pkg;

   localparam int unsigned LINES_PER_WORD = 32;

   typedef enum logic [1:0] {
      ACT_READ  = 2'd0,
      ACT_WRITE = 2'd1,
      ACT_PIN   = 2'd2,
      ACT_IDLE  = 2'd3
   } action_type;

   typedef logic [9:0] offset_type;

   // Group base offsets of the register map.
   localparam offset_type GRP_STA      = 10'h000;
   localparam offset_type GRP_ACK      = 10'h040;
   localparam offset_type GRP_MASK     = 10'h080;
   localparam offset_type GRP_MASK_SET = 10'h0c0;
   localparam offset_type GRP_MASK_CLR = 10'h100;
   localparam offset_type GRP_SENS     = 10'h140;
   localparam offset_type GRP_SENS_SET = 10'h180;
   localparam offset_type GRP_SENS_CLR = 10'h1c0;
   localparam offset_type GRP_POL      = 10'h300;
   localparam offset_type GRP_POL_SET  = 10'h340;
   localparam offset_type GRP_POL_CLR  = 10'h380;

   // Request and response word widths.
   localparam int unsigned REQ_TDATA_W = 56;
   localparam int unsigned RSP_TDATA_W = 40;

endpackage

`default_nettype wire

/* rtl/core/external_interrupt_controller_core.sv */
// Response: registered; it is presented in the cycle after its request word is
// accepted. Throughput: one request word per cycle unless rsp_tready stalls the
// output; a single output register holds the response and the request side
// stays open whenever that register drains. Reset: synchronous, active high;
// all lines masked, edge mode, active low, nothing pending, pin levels low.
//------------------------------------------------------------------------------
// external_interrupt_controller_core
// Per-line interrupt controller with status, acknowledge, mask, sense and
// polarity registers and set/clear aliases, driven by bus and pin words.
//------------------------------------------------------------------------------
`default_nettype none

module external_interrupt_controller_core #(
   parameter int unsigned LINE_COUNT = 64
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // action[1:0], offset[11:2], write_data[43:12], pin_line[49:44],
   // pin_level[50], zero fill above
   input  wire logic [eic_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // read_data[31:0], irq[32], bad_offset[33], zero fill above
   output logic [eic_pkg::RSP_TDATA_W-1:0]         rsp_tdata
);

   import eic_pkg::*;

   localparam int unsigned NumWords = (LINE_COUNT + LINES_PER_WORD - 1) / LINES_PER_WORD;

   // Request fields
   action_type        action;
   offset_type        offset;
   logic [31:0]       write_data;
   logic [5:0]        pin_line;
   logic              pin_level;

   assign action     = action_type'(req_tdata[1:0]);
   assign offset     = req_tdata[11:2];
   assign write_data = req_tdata[43:12];
   assign pin_line   = req_tdata[49:44];
   assign pin_level  = req_tdata[50];

   // State
   logic [LINE_COUNT-1:0] mask_ff,   mask_in;
   logic [LINE_COUNT-1:0] sense_ff,  sense_in;
   logic [LINE_COUNT-1:0] pol_ff,    pol_in;
   logic [LINE_COUNT-1:0] status_ff, status_in;
   logic [LINE_COUNT-1:0] pins_ff,   pins_in;
   logic [LINE_COUNT-1:0] prev_ff,   prev_in;

   logic              rsp_valid_ff;
   logic [31:0]       read_data_ff, read_data_in;
   logic              irq_ff,       irq_in;
   logic              bad_ff,       bad_in;

   logic              accept;
   offset_type        group;
   logic              group_known;
   logic              decoded;
   logic [63:0]       bits_wide;
   logic [63:0]       wmask_wide;
   logic [LINE_COUNT-1:0] bits;
   logic [LINE_COUNT-1:0] wmask;
   logic [LINE_COUNT-1:0] active;
   logic [LINE_COUNT-1:0] src;
   logic [63:0]       src_wide;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign group = {offset[9:6], 6'b0};
   assign group_known = (group == GRP_STA)      || (group == GRP_ACK)      ||
                        (group == GRP_MASK)     || (group == GRP_MASK_SET) ||
                        (group == GRP_MASK_CLR) || (group == GRP_SENS)     ||
                        (group == GRP_SENS_SET) || (group == GRP_SENS_CLR) ||
                        (group == GRP_POL)      || (group == GRP_POL_SET)  ||
                        (group == GRP_POL_CLR);
   assign decoded = (offset[1:0] == 2'b00) && group_known &&
                    (32'(offset[5:2]) < NumWords);

   // Only word 0 or 1 can decode, so offset bit 2 picks the half.
   assign bits_wide  = offset[2] ? {write_data, 32'b0} : {32'b0, write_data};
   assign wmask_wide = offset[2] ? {32'hffff_ffff, 32'b0} : {32'b0, 32'hffff_ffff};
   assign bits       = bits_wide[LINE_COUNT-1:0];
   assign wmask      = wmask_wide[LINE_COUNT-1:0];

   always_comb begin
      mask_in  = mask_ff;
      sense_in = sense_ff;
      pol_in   = pol_ff;
      pins_in  = pins_ff;
      status_in = status_ff;
      if (action == ACT_WRITE && decoded) begin
         case (group)
            GRP_ACK:      status_in = status_ff & ~bits;
            GRP_MASK:     mask_in   = (mask_ff & ~wmask) | bits;
            GRP_MASK_SET: mask_in   = mask_ff | bits;
            GRP_MASK_CLR: mask_in   = mask_ff & ~bits;
            GRP_SENS:     sense_in  = (sense_ff & ~wmask) | bits;
            GRP_SENS_SET: sense_in  = sense_ff | bits;
            GRP_SENS_CLR: sense_in  = sense_ff & ~bits;
            GRP_POL:      pol_in    = (pol_ff & ~wmask) | bits;
            GRP_POL_SET:  pol_in    = pol_ff | bits;
            GRP_POL_CLR:  pol_in    = pol_ff & ~bits;
            default:      ;
         endcase
      end else if (action == ACT_PIN) begin
         for (int i = 0; i < LINE_COUNT; i++) begin
            if (pin_line == 6'(i)) begin
               pins_in[i] = pin_level;
            end
         end
      end

      // Detection sees the state after this word's update.
      active    = ~(pins_in ^ pol_in);
      status_in = status_in | (active & ~prev_ff & ~sense_in) | (active & sense_in);
      prev_in   = active;
   end

   always_comb begin
      case (group)
         GRP_STA:  src = status_in;
         GRP_MASK: src = mask_in;
         GRP_SENS: src = sense_in;
         GRP_POL:  src = pol_in;
         default:  src = '0;
      endcase
      src_wide     = 64'(src);
      read_data_in = '0;
      if (action == ACT_READ && decoded) begin
         read_data_in = offset[2] ? src_wide[63:32] : src_wide[31:0];
      end
      bad_in = ((action == ACT_READ) || (action == ACT_WRITE)) && !decoded;
      irq_in = |(status_in & ~mask_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '1;
         sense_ff     <= '0;
         pol_ff       <= '0;
         status_ff    <= '0;
         pins_ff      <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            mask_ff   <= mask_in;
            sense_ff  <= sense_in;
            pol_ff    <= pol_in;
            status_ff <= status_in;
            pins_ff   <= pins_in;
            prev_ff   <= prev_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= read_data_in;
         irq_ff       <= irq_in;
         bad_ff       <= bad_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, bad_ff, irq_ff, read_data_ff};

endmodule

`default_nettype wire
